// ===== hdl/pmpa_pkg.sv =====
`default_nettype none
package pmpa_pkg;

  localparam logic [1:0] REQ_BYTE = 2'd0;
  localparam logic [1:0] REQ_READ = 2'd1;
  localparam logic [1:0] REQ_TICK = 2'd2;

  localparam logic CFG_WHEEL = 1'b0;
  localparam logic CFG_LIMIT = 1'b1;

  localparam int unsigned LIMIT_W = 24;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 24'd2000000;
  localparam logic [LIMIT_W-1:0] TIMER_MAX = 24'hFFFFFF;
  localparam logic [6:0] SYNC_WRAP = 7'd100;

  localparam int unsigned SYNC_POS = 3;
  localparam int unsigned XSIGN_POS = 4;
  localparam int unsigned YSIGN_POS = 5;

  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] rx_byte;
  } in_beat_t;

  typedef struct packed {
    logic signed [15:0] delta_x;
    logic signed [15:0] delta_y;
    logic signed [7:0]  wheel_sum;
    logic [2:0]         button_bits;
    logic               has_movement;
    logic [6:0]         sync_error_count;
    logic               forced_release;
  } out_beat_t;

  typedef enum logic [1:0] {
    OP_BYTE = 2'd0,
    OP_READ = 2'd1,
    OP_TICK = 2'd2
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data;
  } cmd_t;

  typedef struct packed {
    logic               wheel_packets;
    logic [LIMIT_W-1:0] stuck_limit_ticks;
  } cfg_t;

  function automatic logic signed [8:0] delta9(input logic [7:0] raw, input logic neg);
    logic signed [8:0] d;
    if (!neg) begin
      d = $signed({1'b0, raw});
    end else if (raw < 8'd32) begin
      d = -9'sd16;
    end else begin
      d = $signed({1'b1, raw});
    end
    return d;
  endfunction

  function automatic logic signed [15:0] sat_add(input logic signed [15:0] acc,
                                                 input logic signed [8:0] d);
    logic signed [16:0] sum;
    logic signed [15:0] res;
    sum = {acc[15], acc} + {{8{d[8]}}, d};
    if (sum[16] != sum[15]) begin
      res = sum[16] ? 16'sh8000 : 16'sh7FFF;
    end else begin
      res = sum[15:0];
    end
    return res;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/ps2_mouse_packet_accumulator.sv =====
`default_nettype none
// PS/2 mouse packet accumulator. Takes one beat per clock: a received mouse
// byte, a read request or a time tick. Beats go through a two-entry command
// queue to an execute stage that updates the packet assembly, the saturating
// X/Y accumulators, the wrapping wheel sum, the buttons and the hold timer.
// A read produces one result beat, held in an output register; only reads
// wait on out_stall, so bytes and ticks keep draining while a result sits
// unclaimed, and input stalls only once the queue fills behind a waiting
// read. Registers are written through cfg_wr_en/cfg_index/cfg_data: index 0
// selects four-byte wheel packets, index 1 sets the stuck-button tick limit.
module ps2_mouse_packet_accumulator import pmpa_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire in_beat_t           in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output out_beat_t               out_data,
  input  wire logic               cfg_wr_en,
  input  wire logic               cfg_index,
  input  wire logic [LIMIT_W-1:0] cfg_data
);

  cfg_t cfg_r, cfg_nxt;
  logic q_full;
  logic q_push;
  cmd_t push_entry;
  logic q_pop;
  logic q_valid;
  cmd_t q_entry;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_WHEEL: cfg_nxt.wheel_packets     = cfg_data[0];
        CFG_LIMIT: cfg_nxt.stuck_limit_ticks = cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.wheel_packets     <= 1'b0;
      cfg_r.stuck_limit_ticks <= LIMIT_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  pmpa_front u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_entry  (push_entry)
  );

  pmpa_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .q_valid    (q_valid),
    .q_entry    (q_entry)
  );

  pmpa_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_entry   (q_entry),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

// ===== hdl/pmpa_front.sv =====
`default_nettype none
module pmpa_front import pmpa_pkg::*; (
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_beat_t in_data,
  input  wire logic     q_full,
  output logic          q_push,
  output cmd_t          q_entry
);

  logic known;

  always_comb begin
    known = 1'b1;
    q_entry.data = in_data.rx_byte;
    unique case (in_data.req_type)
      REQ_BYTE: q_entry.op = OP_BYTE;
      REQ_READ: q_entry.op = OP_READ;
      REQ_TICK: q_entry.op = OP_TICK;
      default: begin
        q_entry.op = OP_TICK;
        known = 1'b0;
      end
    endcase
  end

  // unused request code is taken and dropped here
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full && known;

endmodule
`default_nettype wire

// ===== hdl/pmpa_queue.sv =====
`default_nettype none
module pmpa_queue import pmpa_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire cmd_t push_entry,
  output logic      full,
  input  wire logic pop,
  output logic      q_valid,
  output cmd_t      q_entry
);

  cmd_t               slot_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_PTR_W:0]   count_r, count_nxt;

  assign full    = (count_r == (Q_PTR_W+1)'(Q_DEPTH));
  assign q_valid = (count_r != '0);
  assign q_entry = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_PTR_W'(Q_DEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_PTR_W'(Q_DEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/pmpa_back.sv =====
`default_nettype none
module pmpa_back import pmpa_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire cfg_t cfg,
  input  wire logic q_valid,
  input  wire cmd_t q_entry,
  output logic      q_pop,
  output logic      out_valid,
  input  wire logic out_stall,
  output out_beat_t out_data
);

  logic [1:0]          idx_r, idx_nxt;
  logic [7:0]          s0_r, s1_r, s2_r;
  logic signed [15:0]  acc_x_r, acc_x_nxt;
  logic signed [15:0]  acc_y_r, acc_y_nxt;
  logic [7:0]          acc_w_r, acc_w_nxt;
  logic [2:0]          cur_r, cur_nxt;
  logic [2:0]          prev_r, prev_nxt;
  logic [LIMIT_W-1:0]  timer_r, timer_nxt;
  logic                armed_r, armed_nxt;
  logic [6:0]          sync_r, sync_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_beat_t           out_r, out_nxt;

  logic       out_free;
  logic       fire;
  logic       complete;
  logic [7:0] b;
  logic [7:0] ybyte;
  logic [2:0] nb;
  logic       forced;

  assign out_free  = !out_valid_r || !out_stall;
  assign q_pop     = q_valid && ((q_entry.op != OP_READ) || out_free);
  assign fire      = q_pop;
  assign b         = q_entry.data;
  assign complete  = (idx_r >= (cfg.wheel_packets ? 2'd3 : 2'd2));
  assign ybyte     = (idx_r == 2'd2) ? b : s2_r;
  assign nb        = s0_r[2:0];
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    idx_nxt       = idx_r;
    acc_x_nxt     = acc_x_r;
    acc_y_nxt     = acc_y_r;
    acc_w_nxt     = acc_w_r;
    cur_nxt       = cur_r;
    prev_nxt      = prev_r;
    timer_nxt     = timer_r;
    armed_nxt     = armed_r;
    sync_nxt      = sync_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;
    forced        = 1'b0;
    if (fire) begin
      unique case (q_entry.op)
        OP_BYTE: begin
          if (idx_r == 2'd0 && !b[SYNC_POS]) begin
            sync_nxt = (sync_r == SYNC_WRAP) ? '0 : sync_r + 1'b1;
          end else if (complete) begin
            idx_nxt = 2'd0;
            if (s0_r[7:6] == 2'b00) begin
              if (nb != prev_r) begin
                prev_nxt = nb;
                if (nb != 3'd0) begin
                  timer_nxt = '0;
                  armed_nxt = 1'b1;
                end
              end
              cur_nxt   = nb;
              acc_x_nxt = sat_add(acc_x_r, delta9(s1_r, s0_r[XSIGN_POS]));
              acc_y_nxt = sat_add(acc_y_r, delta9(ybyte, s0_r[YSIGN_POS]));
              if (cfg.wheel_packets) begin
                acc_w_nxt = acc_w_r + {{4{b[3]}}, b[3:0]};
              end
            end
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
        OP_TICK: begin
          if (armed_r && timer_r != TIMER_MAX) begin
            timer_nxt = timer_r + 1'b1;
          end
        end
        OP_READ: begin
          forced = (cur_r != 3'd0) && armed_r && (timer_r > cfg.stuck_limit_ticks);
          if (forced) begin
            cur_nxt   = 3'd0;
            prev_nxt  = 3'd0;
            armed_nxt = 1'b0;
          end
          out_valid_nxt            = 1'b1;
          out_nxt.delta_x          = acc_x_r;
          out_nxt.delta_y          = acc_y_r;
          out_nxt.wheel_sum        = $signed(acc_w_r);
          out_nxt.button_bits      = forced ? 3'd0 : cur_r;
          out_nxt.has_movement     = (acc_x_r != 16'sd0) || (acc_y_r != 16'sd0)
                                     || (acc_w_r != 8'd0);
          out_nxt.sync_error_count = sync_r;
          out_nxt.forced_release   = forced;
          acc_x_nxt                = '0;
          acc_y_nxt                = '0;
          acc_w_nxt                = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      acc_x_r     <= '0;
      acc_y_r     <= '0;
      acc_w_r     <= '0;
      cur_r       <= '0;
      prev_r      <= '0;
      timer_r     <= '0;
      armed_r     <= 1'b0;
      sync_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      acc_x_r     <= acc_x_nxt;
      acc_y_r     <= acc_y_nxt;
      acc_w_r     <= acc_w_nxt;
      cur_r       <= cur_nxt;
      prev_r      <= prev_nxt;
      timer_r     <= timer_nxt;
      armed_r     <= armed_nxt;
      sync_r      <= sync_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // packet bytes and result beat, no reset
  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    if (fire && q_entry.op == OP_BYTE && !(idx_r == 2'd0 && !b[SYNC_POS])) begin
      if (idx_r == 2'd0) begin
        s0_r <= b;
      end
      if (idx_r == 2'd1) begin
        s1_r <= b;
      end
      if (idx_r == 2'd2) begin
        s2_r <= b;
      end
    end
  end

endmodule
`default_nettype wire

// ===== hdl/pmpa_checker.sv =====
`default_nettype none
module pmpa_checker import pmpa_pkg::*; (
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire out_beat_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  a_sync_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.sync_error_count <= SYNC_WRAP)
    else $error("sync error count out of range");

  a_forced_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.forced_release |-> out_data.button_bits == 3'd0)
    else $error("forced release with buttons still set");

  a_movement_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.has_movement |->
      out_data.delta_x == 16'sd0 && out_data.delta_y == 16'sd0
      && out_data.wheel_sum == 8'sd0)
    else $error("movement flag clear with nonzero sums");

endmodule

bind ps2_mouse_packet_accumulator pmpa_checker u_pmpa_checker (.*);
`default_nettype wire

// ===== tb/ps2_mouse_packet_accumulator_tb.sv =====
module ps2_mouse_packet_accumulator_tb;
  import pmpa_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 12;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_beat_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_beat_t out_data;
  logic cfg_wr_en = 1'b0;
  logic cfg_index = 1'b0;
  logic [LIMIT_W-1:0] cfg_data = '0;

  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;
  int beats_taken = 0;
  int errors = 0;
  int cycle_count = 0;
  out_beat_t reports_due[$];

  // mirror of the block state
  logic wheel_mode = 1'b0;
  logic [LIMIT_W-1:0] stuck_limit = LIMIT_RESET;
  logic [1:0] pkt_pos = '0;
  logic [7:0] pkt_bytes[3] = '{default: 8'h00};
  logic signed [15:0] sum_x = '0;
  logic signed [15:0] sum_y = '0;
  logic [7:0] sum_wheel = '0;
  logic [2:0] btn_now = '0;
  logic [2:0] btn_prev = '0;
  logic [LIMIT_W-1:0] hold_ticks = '0;
  logic hold_on = 1'b0;
  logic [6:0] bad_sync = '0;

  ps2_mouse_packet_accumulator dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < rcv_idle_pct);
  end

  function automatic int move9(input logic [7:0] raw, input logic neg);
    if (!neg) return int'(raw);
    if (raw < 8'd32) return -16;
    return int'(raw) - 256;
  endfunction

  function automatic logic signed [15:0] clamp16(input int v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic void apply_mouse_beat(input in_beat_t b);
    int size;
    logic [7:0] st;
    logic [7:0] yb;
    logic [2:0] nb;
    logic forced;
    out_beat_t r;
    case (b.req_type)
      REQ_BYTE: begin
        size = wheel_mode ? 4 : 3;
        if (pkt_pos == 2'd0 && !b.rx_byte[SYNC_POS]) begin
          if (bad_sync == SYNC_WRAP) bad_sync = '0;
          else bad_sync = bad_sync + 7'd1;
        end else begin
          if (pkt_pos < 2'd3) pkt_bytes[pkt_pos] = b.rx_byte;
          if (pkt_pos + 1 >= size) begin
            yb = (pkt_pos == 2'd2) ? b.rx_byte : pkt_bytes[2];
            st = pkt_bytes[0];
            if (st[7:6] == 2'b00) begin
              nb = st[2:0];
              if (nb != btn_prev) begin
                btn_prev = nb;
                if (nb != 3'd0) begin
                  hold_ticks = '0;
                  hold_on = 1'b1;
                end
              end
              btn_now = nb;
              sum_x = clamp16(int'(sum_x) + move9(pkt_bytes[1], st[XSIGN_POS]));
              sum_y = clamp16(int'(sum_y) + move9(yb, st[YSIGN_POS]));
              if (size == 4) begin
                sum_wheel = sum_wheel + {{4{b.rx_byte[3]}}, b.rx_byte[3:0]};
              end
            end
            pkt_pos = 2'd0;
          end else begin
            pkt_pos = pkt_pos + 2'd1;
          end
        end
      end
      REQ_TICK: begin
        if (hold_on && hold_ticks != TIMER_MAX) hold_ticks = hold_ticks + 1'b1;
      end
      REQ_READ: begin
        forced = 1'b0;
        if (btn_now != 3'd0 && hold_on && hold_ticks > stuck_limit) begin
          btn_now = '0;
          btn_prev = '0;
          hold_on = 1'b0;
          forced = 1'b1;
        end
        r.delta_x = sum_x;
        r.delta_y = sum_y;
        r.wheel_sum = sum_wheel;
        r.button_bits = btn_now;
        r.has_movement = (sum_x != 0 || sum_y != 0 || sum_wheel != 0);
        r.sync_error_count = bad_sync;
        r.forced_release = forced;
        reports_due.push_back(r);
        sum_x = '0;
        sum_y = '0;
        sum_wheel = '0;
      end
      default: begin
      end
    endcase
  endfunction

  task automatic flag_mismatch(input string what, input int got_v, input int exp_v);
    $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got_v,
             exp_v);
    errors++;
  endtask

  task automatic check_report(input out_beat_t got);
    out_beat_t want;
    if (reports_due.size() == 0) begin
      flag_mismatch("result beat with no read waiting", int'(got.delta_x), 0);
    end else begin
      want = reports_due.pop_front();
      if (got.delta_x !== want.delta_x)
        flag_mismatch("delta_x", int'(got.delta_x), int'(want.delta_x));
      if (got.delta_y !== want.delta_y)
        flag_mismatch("delta_y", int'(got.delta_y), int'(want.delta_y));
      if (got.wheel_sum !== want.wheel_sum)
        flag_mismatch("wheel_sum", int'(got.wheel_sum), int'(want.wheel_sum));
      if (got.button_bits !== want.button_bits)
        flag_mismatch("button_bits", int'(got.button_bits), int'(want.button_bits));
      if (got.has_movement !== want.has_movement)
        flag_mismatch("has_movement", int'(got.has_movement), int'(want.has_movement));
      if (got.sync_error_count !== want.sync_error_count)
        flag_mismatch("sync_error_count", int'(got.sync_error_count),
                      int'(want.sync_error_count));
      if (got.forced_release !== want.forced_release)
        flag_mismatch("forced_release", int'(got.forced_release), int'(want.forced_release));
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) check_report(out_data);
      if (in_valid && !in_stall) begin
        apply_mouse_beat(in_data);
        beats_taken++;
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL ps2_mouse_packet_accumulator");
    $finish;
  end

  task automatic send_beat(input logic [1:0] kind, input logic [7:0] data);
    int n;
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    n = beats_taken;
    in_valid <= 1'b1;
    in_data <= '{req_type: kind, rx_byte: data};
    do @(negedge clk); while (beats_taken == n);
  endtask

  task automatic send_packet(input logic [7:0] st, input logic [7:0] x, input logic [7:0] y,
                             input logic [7:0] w);
    send_beat(REQ_BYTE, st);
    send_beat(REQ_BYTE, x);
    send_beat(REQ_BYTE, y);
    if (wheel_mode) send_beat(REQ_BYTE, w);
  endtask

  task automatic request_read();
    send_beat(REQ_READ, 8'($urandom));
  endtask

  task automatic send_tick();
    send_beat(REQ_TICK, 8'($urandom));
  endtask

  task automatic drain_reports();
    in_valid <= 1'b0;
    do @(negedge clk); while (reports_due.size() != 0);
  endtask

  task automatic write_reg(input logic idx, input logic [LIMIT_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == CFG_WHEEL) wheel_mode = val[0];
    else stuck_limit = val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_config(input logic wheel, input logic [LIMIT_W-1:0] limit);
    drain_reports();
    repeat (DRAIN_CYCLES) @(negedge clk);
    write_reg(CFG_WHEEL, {{(LIMIT_W-1){1'b0}}, wheel});
    write_reg(CFG_LIMIT, limit);
  endtask

  function automatic logic [LIMIT_W-1:0] pick_limit();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return TIMER_MAX;
      2: return LIMIT_RESET;
      default: return LIMIT_W'($urandom_range(1, 12));
    endcase
  endfunction

  task automatic test_reset_read();
    request_read();
  endtask

  task automatic test_packet_fields();
    send_packet(8'h0F, 8'hFF, 8'h00, 8'h00);
    // corrupt negative x, most negative y
    send_packet(8'h3F, 8'h1F, 8'h20, 8'h00);
    // x overflow, then y overflow: both dropped
    send_packet(8'h48, 8'h55, 8'hAA, 8'h00);
    send_packet(8'h88, 8'hFF, 8'hFF, 8'h00);
    request_read();
  endtask

  task automatic test_sync_skip();
    send_beat(REQ_BYTE, 8'h00);
    send_beat(REQ_BYTE, 8'hF7);
    request_read();
  endtask

  task automatic test_unused_request();
    send_beat(REQ_UNUSED, 8'hFF);
    request_read();
  endtask

  task automatic test_wheel_packets();
    set_config(1'b1, LIMIT_RESET);
    send_packet(8'h09, 8'h01, 8'h80, 8'hF8);
    request_read();
  endtask

  task automatic test_stuck_release();
    set_config(1'b0, '0);
    send_packet(8'h0B, 8'h00, 8'h00, 8'h00);
    request_read();
    send_tick();
    request_read();
  endtask

  task automatic test_saturation(input logic [7:0] st, input logic [7:0] x,
                                 input logic [7:0] y);
    set_config(1'b0, pick_limit());
    repeat (150) send_packet(st, x, y, 8'h00);
    request_read();
  endtask

  task automatic test_sync_wrap();
    set_config(1'b0, pick_limit());
    repeat (105) begin
      send_beat(REQ_BYTE, 8'($urandom) & 8'hF7);
      if ($urandom_range(0, 19) == 0) request_read();
    end
    request_read();
  endtask

  task automatic test_random_traffic(input int n);
    int sent;
    int pick;
    int k;
    logic [7:0] st;
    set_config(1'($urandom_range(0, 1)), pick_limit());
    sent = 0;
    while (sent < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        st = 8'($urandom) | 8'h08;
        if ($urandom_range(0, 7) != 0) st[7:6] = 2'b00;
        send_packet(st, 8'($urandom), 8'($urandom), 8'($urandom));
        sent += wheel_mode ? 4 : 3;
      end else if (pick < 65) begin
        request_read();
        sent++;
      end else if (pick < 82) begin
        k = $urandom_range(1, 6);
        repeat (k) send_tick();
        sent += k;
      end else if (pick < 95) begin
        // stray byte, may break framing
        send_beat(REQ_BYTE, 8'($urandom));
        sent++;
      end else if (pick < 98) begin
        send_beat(REQ_UNUSED, 8'($urandom));
      end else begin
        drain_reports();
      end
    end
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_read();
    test_packet_fields();
    test_sync_skip();
    test_unused_request();
    test_wheel_packets();
    test_stuck_release();

    snd_idle_pct = 6;
    rcv_idle_pct = 81;
    test_saturation(8'h28, 8'hFF, 8'h20);
    test_sync_wrap();
    repeat (3) test_random_traffic(40);

    snd_idle_pct = 81;
    rcv_idle_pct = 6;
    test_saturation(8'h18, 8'h20, 8'hFF);
    repeat (3) test_random_traffic(40);

    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    repeat (3) test_random_traffic(40);

    drain_reports();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0) begin
      $display("PASS ps2_mouse_packet_accumulator");
    end else begin
      $display("FAIL ps2_mouse_packet_accumulator");
    end
    $finish;
  end

endmodule
